[rtl/core/assert_macros.svh]
// assertion macros shared by the servo sweep block
// clk and rst are taken from the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SSDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SSDB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSDB_ASSERT(lbl, prop, msg)

`define SSDB_ASSERT_RST(lbl, prop, msg)

`endif

`endif

[rtl/core/ssdb_pkg.sv]
// shared types and constants of the servo sweep lock and digit blinker
// no dependencies
`default_nettype none

package ssdb_pkg;

  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PTIME_W  = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd100;
  localparam logic [ANGLE_W-1:0]  SWEEP_LOW_RST   = 8'd20;
  localparam logic [ANGLE_W-1:0]  SWEEP_HIGH_RST  = 8'd160;
  localparam logic [ANGLE_W-1:0]  START_ANGLE_RST = 8'd90;

  localparam logic [PTIME_W-1:0] FLASH_MS     = 12'd300;
  localparam logic [PTIME_W-1:0] DIGIT_GAP_MS = 12'd1000;
  localparam logic [PTIME_W-1:0] FINAL_GAP_MS = 12'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD = 2'd0,
    REG_SWEEP_LOW   = 2'd1,
    REG_SWEEP_HIGH  = 2'd2,
    REG_START_ANGLE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_RED   = 2'd1,
    LED_GREEN = 2'd2,
    LED_BLUE  = 2'd3
  } led_color_t;

  typedef enum logic [1:0] {
    PHASE_HUNDREDS = 2'd0,
    PHASE_TENS     = 2'd1,
    PHASE_UNITS    = 2'd2,
    PHASE_FINAL    = 2'd3
  } digit_phase_t;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  typedef struct packed {
    logic               lock_start;
    logic               locked;
    logic [ANGLE_W-1:0] angle;
    logic               locked_next;
    logic [ANGLE_W-1:0] angle_next;
  } sweep_status_t;

endpackage

`default_nettype wire

[rtl/core/ssdb_ifs.sv]
// channel interfaces: tick input, result output and register write port
// depends on ssdb_pkg
`default_nettype none

interface ssdb_tick_if;
  logic valid;
  logic ready;
  logic object_detected;

  modport source (output valid, output object_detected, input ready);
  modport sink   (input valid, input object_detected, output ready);
endinterface

interface ssdb_result_if import ssdb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] servo_angle;
  logic [1:0]         led_color;
  logic               is_locked;

  modport source (output valid, output servo_angle, output led_color, output is_locked,
                  input ready);
  modport sink   (input valid, input servo_angle, input led_color, input is_locked,
                  output ready);
endinterface

interface ssdb_cfg_if import ssdb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/ssdb_sweep.sv]
// sweep part: config registers, step timer, angle and lock flag
// depends on ssdb_pkg and ssdb_cfg_if
`default_nettype none

module ssdb_sweep import ssdb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  ssdb_cfg_if.sink      cfg,
  input  wire logic     advance,
  input  wire logic     detect,
  output sweep_status_t status
);

  logic [PERIOD_W-1:0] step_period;
  logic [ANGLE_W-1:0]  sweep_low;
  logic [ANGLE_W-1:0]  sweep_high;

  logic [ANGLE_W-1:0]  angle;
  logic [PERIOD_W-1:0] step_timer;
  logic                locked;

  logic [ANGLE_W-1:0]  angle_next;
  logic [PERIOD_W-1:0] step_timer_next;
  logic                locked_next;
  logic [PERIOD_W-1:0] timer_inc;
  logic [ANGLE_W:0]    angle_inc;
  logic                lock_start;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= STEP_PERIOD_RST;
      sweep_low   <= SWEEP_LOW_RST;
      sweep_high  <= SWEEP_HIGH_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_STEP_PERIOD: step_period <= cfg.data;
        REG_SWEEP_LOW:   sweep_low   <= cfg.data[ANGLE_W-1:0];
        REG_SWEEP_HIGH:  sweep_high  <= cfg.data[ANGLE_W-1:0];
        // start angle is reloaded with its reset value on every reset
        REG_START_ANGLE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    lock_start      = !locked && detect;
    timer_inc       = (step_timer < step_period) ? step_timer + 16'd1 : step_timer;
    angle_inc       = {1'b0, angle} + 9'd1;
    angle_next      = angle;
    step_timer_next = step_timer;
    locked_next     = locked;
    if (lock_start) begin
      locked_next = 1'b1;
    end else if (!locked) begin
      if (timer_inc >= step_period) begin
        angle_next      = (angle_inc > {1'b0, sweep_high}) ? sweep_low : angle_inc[ANGLE_W-1:0];
        step_timer_next = '0;
      end else begin
        step_timer_next = timer_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle      <= START_ANGLE_RST;
      step_timer <= '0;
      locked     <= 1'b0;
    end else if (advance) begin
      angle      <= angle_next;
      step_timer <= step_timer_next;
      locked     <= locked_next;
    end
  end

  always_comb begin
    status.lock_start  = lock_start;
    status.locked      = locked;
    status.angle       = angle;
    status.locked_next = locked_next;
    status.angle_next  = angle_next;
  end

endmodule

`default_nettype wire

[rtl/core/ssdb_blinker.sv]
// digit blinker: saved digits, phase, flash count and phase timer
// depends on ssdb_pkg
`default_nettype none

module ssdb_blinker import ssdb_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire sweep_status_t  status,
  output led_color_t          color
);

  digits_t         digits;
  digit_phase_t    phase;
  logic [3:0]      flash_count;
  logic            led_lit;
  logic [PTIME_W-1:0] phase_timer;

  digits_t         digits_eff;
  digit_phase_t    phase_eff;
  logic [3:0]      flash_eff;
  logic            lit_eff;
  logic [PTIME_W-1:0] ptime_eff;
  logic            active;

  digit_phase_t    phase_next;
  logic [3:0]      flash_count_next;
  logic            led_lit_next;
  logic [PTIME_W-1:0] phase_timer_next;
  logic [PTIME_W-1:0] ptime_inc;
  logic [PTIME_W-1:0] seg_len;
  logic [3:0]      cur_digit;
  logic [3:0]      flash_inc;
  digit_phase_t    phase_adv;

  function automatic digits_t split_digits(input logic [ANGLE_W-1:0] a);
    digits_t    d;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [6:0] tens_x10;
    if (a >= 8'd200) begin
      d.hundreds = 2'd2;
      rem        = 7'(a - 8'd200);
    end else if (a >= 8'd100) begin
      d.hundreds = 2'd1;
      rem        = 7'(a - 8'd100);
    end else begin
      d.hundreds = 2'd0;
      rem        = a[6:0];
    end
    // rem below 100, so times 205 over 2048 is exact
    prod     = 15'(rem) * 15'd205;
    d.tens   = prod[14:11];
    tens_x10 = 7'(d.tens) * 7'd10;
    d.units  = 4'(rem - tens_x10);
    return d;
  endfunction

  function automatic logic [3:0] digit_of(input digits_t d, input digit_phase_t p);
    logic [3:0] v;
    unique case (p)
      PHASE_HUNDREDS: v = {2'b00, d.hundreds};
      PHASE_TENS:     v = d.tens;
      PHASE_UNITS:    v = d.units;
      PHASE_FINAL:    v = 4'd0;
      default:        v = 4'd0;
    endcase
    return v;
  endfunction

  always_comb begin
    active = status.locked || status.lock_start;
    if (status.lock_start) begin
      digits_eff = split_digits(status.angle);
      phase_eff  = PHASE_HUNDREDS;
      flash_eff  = 4'd0;
      lit_eff    = (digits_eff.hundreds != 2'd0);
      ptime_eff  = '0;
    end else begin
      digits_eff = digits;
      phase_eff  = phase;
      flash_eff  = flash_count;
      lit_eff    = led_lit;
      ptime_eff  = phase_timer;
    end
  end

  always_comb begin
    color = LED_OFF;
    if (active && lit_eff) begin
      unique case (phase_eff)
        PHASE_HUNDREDS: color = LED_RED;
        PHASE_TENS:     color = LED_GREEN;
        PHASE_UNITS:    color = LED_BLUE;
        PHASE_FINAL:    color = LED_OFF;
        default:        color = LED_OFF;
      endcase
    end
  end

  always_comb begin
    cur_digit = digit_of(digits_eff, phase_eff);
    ptime_inc = ptime_eff + 12'd1;
    flash_inc = flash_eff + 4'd1;
    unique case (phase_eff)
      PHASE_HUNDREDS: phase_adv = PHASE_TENS;
      PHASE_TENS:     phase_adv = PHASE_UNITS;
      PHASE_UNITS:    phase_adv = PHASE_FINAL;
      PHASE_FINAL:    phase_adv = PHASE_HUNDREDS;
      default:        phase_adv = PHASE_HUNDREDS;
    endcase
    if (flash_eff < cur_digit) begin
      seg_len = FLASH_MS;
    end else if (phase_eff != PHASE_FINAL) begin
      seg_len = DIGIT_GAP_MS;
    end else begin
      seg_len = FINAL_GAP_MS;
    end

    phase_next       = phase_eff;
    flash_count_next = flash_eff;
    led_lit_next     = lit_eff;
    phase_timer_next = ptime_inc;
    if (ptime_inc >= seg_len) begin
      phase_timer_next = '0;
      if (flash_eff < cur_digit) begin
        if (lit_eff) begin
          led_lit_next = 1'b0;
        end else begin
          flash_count_next = flash_inc;
          led_lit_next     = (flash_inc < cur_digit);
        end
      end else begin
        phase_next       = phase_adv;
        flash_count_next = 4'd0;
        led_lit_next     = (digit_of(digits_eff, phase_adv) != 4'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits      <= '0;
      phase       <= PHASE_HUNDREDS;
      flash_count <= '0;
      led_lit     <= 1'b0;
      phase_timer <= '0;
    end else if (advance && active) begin
      digits      <= digits_eff;
      phase       <= phase_next;
      flash_count <= flash_count_next;
      led_lit     <= led_lit_next;
      phase_timer <= phase_timer_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/servo_sweep_lock_digit_blinker_top.sv]
// an accepted tick beat passes the input register and then the result register to its result beat
// throughput: one tick beat per cycle while the result side does not stall, set by the single state update stage
// an input register and a result register part the two handshakes
// reset: synchronous, clears valids, angle to 90, unlocked, registers to defaults
// depends on ssdb_pkg, ssdb_ifs, ssdb_sweep, ssdb_blinker, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module servo_sweep_lock_digit_blinker_top import ssdb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ssdb_tick_if.sink  sensor,
  ssdb_result_if.source result,
  ssdb_cfg_if.sink   cfg
);

  logic          in_valid;
  logic          in_detect;
  logic          out_valid;
  logic          advance;
  sweep_status_t status;
  led_color_t    color_next;

  logic [ANGLE_W-1:0] out_angle;
  logic [1:0]         out_color;
  logic               out_locked;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sensor.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensor.ready) begin
      in_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.ready && sensor.valid) begin
      in_detect <= sensor.object_detected;
    end
  end

  ssdb_sweep u_sweep (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .detect  (in_detect),
    .status  (status)
  );

  ssdb_blinker u_blinker (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .status  (status),
    .color   (color_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_angle  <= status.angle_next;
      out_color  <= color_next;
      out_locked <= status.locked_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.servo_angle = out_angle;
  assign result.led_color   = out_color;
  assign result.is_locked   = out_locked;

  // lock is sticky and freezes the angle
  `SSDB_ASSERT(a_lock_sticky, status.locked |=> status.locked, "lock flag dropped")
  `SSDB_ASSERT(a_angle_frozen, status.locked |=> $stable(status.angle), "angle moved while locked")
  // lit led only on a locked result beat
  `SSDB_ASSERT(a_led_needs_lock, (out_valid && out_color != LED_OFF) |-> out_locked,
               "led lit before lock")
  // a processed tick always lands in the result register
  `SSDB_ASSERT(a_advance_result, advance |=> out_valid, "result beat lost")
  `SSDB_ASSERT_RST(a_reset_clears, rst |=> (!out_valid && !in_valid && !status.locked),
                   "reset did not clear control state")

endmodule

`default_nettype wire

[verif/servo_sweep_lock_digit_blinker_top_test.sv]
// self-checking test of the servo sweep lock and digit blinker top level
// predicts every result beat from its own model of sweep, lock and flash pattern
// depends on ssdb_pkg, ssdb_ifs and servo_sweep_lock_digit_blinker_top
`default_nettype none

module servo_sweep_lock_digit_blinker_top_test;
  import ssdb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [ANGLE_W-1:0] servo_angle;
    led_color_t         led_color;
    logic               is_locked;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssdb_tick_if   sensor ();
  ssdb_result_if result ();
  ssdb_cfg_if    cfg ();

  servo_sweep_lock_digit_blinker_top u_top (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sweep and blinker state as the block should hold it
  logic [PERIOD_W-1:0] cfg_period = STEP_PERIOD_RST;
  logic [ANGLE_W-1:0]  cfg_low    = SWEEP_LOW_RST;
  logic [ANGLE_W-1:0]  cfg_high   = SWEEP_HIGH_RST;
  logic [ANGLE_W-1:0]  cfg_start  = START_ANGLE_RST;
  logic [ANGLE_W-1:0]  cur_angle  = START_ANGLE_RST;
  logic [PERIOD_W-1:0] step_count = '0;
  logic                locked     = 1'b0;
  digit_phase_t        phase      = PHASE_HUNDREDS;
  logic [3:0]          flashes_done = '0;
  logic                lamp_on    = 1'b0;
  logic [PTIME_W-1:0]  phase_ms   = '0;
  digits_t             shown_digits = '0;

  beat_t expected_beats[$];
  bit    broken     = 1'b0;
  bit    idling_on  = 1'b1;
  int    ready_stall = 0;
  int    quiet_cycles = 0;

  function automatic logic [3:0] digit_value(digit_phase_t p);
    case (p)
      PHASE_HUNDREDS: return {2'b00, shown_digits.hundreds};
      PHASE_TENS:     return shown_digits.tens;
      PHASE_UNITS:    return shown_digits.units;
      default:        return 4'd0;
    endcase
  endfunction

  function automatic logic [PTIME_W-1:0] segment_ms();
    if (flashes_done < digit_value(phase)) return FLASH_MS;
    if (phase != PHASE_FINAL) return DIGIT_GAP_MS;
    return FINAL_GAP_MS;
  endfunction

  function automatic void advance_blink();
    phase_ms = phase_ms + 1'b1;
    if (phase_ms < segment_ms()) return;
    phase_ms = '0;
    if (flashes_done < digit_value(phase)) begin
      if (lamp_on) begin
        lamp_on = 1'b0;
      end else begin
        flashes_done = flashes_done + 1'b1;
        lamp_on = flashes_done < digit_value(phase);
      end
    end else begin
      phase = (phase == PHASE_FINAL) ? PHASE_HUNDREDS : digit_phase_t'(2'(phase) + 2'd1);
      flashes_done = '0;
      lamp_on = digit_value(phase) != 4'd0;
    end
  endfunction

  function automatic void predict_tick(logic detect);
    led_color_t         colour;
    logic [ANGLE_W:0]   next_angle;
    colour = LED_OFF;
    if (!locked && detect) begin
      shown_digits.hundreds = 2'(cur_angle / 8'd100);
      shown_digits.tens     = 4'((cur_angle % 8'd100) / 8'd10);
      shown_digits.units    = 4'(cur_angle % 8'd10);
      locked       = 1'b1;
      phase        = PHASE_HUNDREDS;
      flashes_done = '0;
      phase_ms     = '0;
      lamp_on      = shown_digits.hundreds != 2'd0;
    end else if (!locked) begin
      if (step_count < cfg_period) step_count = step_count + 1'b1;
      if (step_count >= cfg_period) begin
        next_angle = {1'b0, cur_angle} + 1'b1;
        cur_angle  = (next_angle > {1'b0, cfg_high}) ? cfg_low : next_angle[ANGLE_W-1:0];
        step_count = '0;
      end
    end
    if (locked) begin
      if (lamp_on && phase != PHASE_FINAL) colour = led_color_t'(2'(phase) + 2'd1);
      advance_blink();
    end
    expected_beats.push_back(beat_t'{cur_angle, colour, locked});
  endfunction

  function automatic void store_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_STEP_PERIOD: cfg_period = value;
      REG_SWEEP_LOW:   cfg_low    = value[ANGLE_W-1:0];
      REG_SWEEP_HIGH:  cfg_high   = value[ANGLE_W-1:0];
      REG_START_ANGLE: cfg_start  = value[ANGLE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 180));
  endfunction

  task automatic send_tick(input logic detect);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      sensor.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    sensor.valid           <= 1'b1;
    sensor.object_detected <= detect;
    do @(posedge clk); while (!sensor.ready);
    predict_tick(detect);
  endtask

  task automatic finish_batch();
    sensor.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick(1'b0);
    finish_batch();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    store_reg(idx, value);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] period, input logic [CFG_DATA_W-1:0] low,
                              input logic [CFG_DATA_W-1:0] high, input logic [CFG_DATA_W-1:0] start);
    write_reg(REG_STEP_PERIOD, period);
    write_reg(REG_SWEEP_LOW, low);
    write_reg(REG_SWEEP_HIGH, high);
    write_reg(REG_START_ANGLE, start);
    cfg.valid <= 1'b0;
  endtask

  task automatic test_default_period();
    run_ticks(101);
  endtask

  task automatic test_period_extremes();
    program_regs(16'hFFFF, 16'd20, 16'd160, 16'd90);
    run_ticks(8);
    // zero period steps on every tick
    program_regs(16'd0, 16'd20, 16'd160, 16'd255);
    run_ticks(5);
  endtask

  task automatic test_sweep_bounds();
    // low above high loads low on every step past high
    program_regs(16'd1, 16'd178, 16'd100, 16'd0);
    run_ticks(2);
    program_regs(16'd1, 16'd178, 16'd180, 16'd180);
    run_ticks(5);
    program_regs(16'd0, 16'd250, 16'd0, 16'd0);
    run_ticks(1);
    // out of range angle, 255 wraps to low and not to 0
    program_regs(16'd1, 16'd250, 16'd255, 16'd255);
    run_ticks(8);
    program_regs(16'd1, 16'd0, 16'd0, 16'd0);
    run_ticks(3);
    program_regs(16'd1, 16'd0, 16'd180, 16'd90);
    run_ticks(3);
  endtask

  task automatic test_random_sweep();
    logic [CFG_DATA_W-1:0] period;
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] high;
    logic [CFG_DATA_W-1:0] start;
    repeat (6) begin
      case ($urandom_range(0, 9))
        0:       period = 16'($urandom_range(0, 65535));
        1, 2:    period = 16'($urandom_range(5, 40));
        default: period = 16'($urandom_range(0, 4));
      endcase
      low   = 16'($urandom_range(0, 65535));
      high  = 16'($urandom_range(0, 65535));
      start = 16'($urandom_range(0, 65535));
      low[ANGLE_W-1:0]   = pick_angle();
      high[ANGLE_W-1:0]  = pick_angle();
      start[ANGLE_W-1:0] = pick_angle();
      program_regs(period, low, high, start);
      run_ticks($urandom_range(30, 70));
    end
  endtask

  task automatic test_lock_and_blink();
    logic [ANGLE_W-1:0] lock_angles [6] = '{8'd215, 8'd201, 8'd210, 8'd255, 8'd47, 8'd100};
    logic [ANGLE_W-1:0] target;
    int                 ticks;
    target = lock_angles[$urandom_range(0, 5)];
    // high of zero makes every step load the target
    program_regs(16'd1, {8'd0, target}, 16'd0, 16'd90);
    repeat (2) send_tick(1'b0);
    send_tick(1'b1);
    ticks = 1200;
    for (int i = 1; i < ticks; i++) begin
      if (i == 600) begin
        // writes while locked leave the frozen angle and pattern alone
        finish_batch();
        program_regs(16'd1, 16'd0, 16'd180, 16'd33);
      end
      if (i == ticks - 400) idling_on = 1'b0;
      send_tick(1'($urandom_range(0, 1)));
    end
    finish_batch();
  endtask

  // result side stalls at random while idling is on
  always @(posedge clk) begin
    if (ready_stall != 0) begin
      ready_stall  <= ready_stall - 1;
      result.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      ready_stall  <= $urandom_range(0, 9);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beat
    beat_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no tick outstanding");
        broken = 1'b1;
      end else begin
        want = expected_beats.pop_front();
        if (result.servo_angle !== want.servo_angle) begin
          $error("servo_angle expected %0d got %0d", want.servo_angle, result.servo_angle);
          broken = 1'b1;
        end
        if (result.led_color !== want.led_color) begin
          $error("led_color expected %0d got %0d", want.led_color, result.led_color);
          broken = 1'b1;
        end
        if (result.is_locked !== want.is_locked) begin
          $error("is_locked expected %0d got %0d", want.is_locked, result.is_locked);
          broken = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sensor.valid && sensor.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sensor.valid           <= 1'b0;
    sensor.object_detected <= 1'b0;
    cfg.valid              <= 1'b0;
    cfg.index              <= REG_STEP_PERIOD;
    cfg.data               <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_period();
    test_period_extremes();
    test_sweep_bounds();
    test_random_sweep();
    test_lock_and_blink();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (broken)
      $display("[FAIL] regression broken");
    else
      $display("[ OK ] regression clean");
    $finish;
  end

endmodule

`default_nettype wire
